// ----- rtl/lkvt_pkg.sv -----
`default_nettype none

package lkvt_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 5;

	localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ACCESS = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// per-word command broadcast to every cell
	typedef struct packed {
		logic del;   // delete of a present key: close the gap
		logic wr;    // write of a present key
		logic ins;   // append at the tail
	} lkvt_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/linear_key_value_table.sv -----
// Output: the result word of an accepted word is registered in the output register.
// Throughput: one word per cycle while req_stall is low; every cell compares its key in parallel and the
// delete shift moves all later cells down by one in the same edge.
// Reset: arst_n clears the fill count and the output valid; the cell contents
// are left as they are and only slots below the fill count are ever read.
`default_nettype none

module linear_key_value_table
	import lkvt_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int KEY_BITS   = DEF_KEY_BITS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic signed [31:0]  key,
	input  wire logic signed [31:0]  value,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic signed [31:0]       read_value,
	output logic                     was_found,
	output logic [STATUS_W-1:0]      status,
	output logic [TOTAL_W-1:0]       entry_total
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                          accept;
	logic signed [KEY_BITS-1:0]    k;
	logic signed [VALUE_BITS-1:0]  v;
	logic [CNT_W-1:0]              count_q;
	logic                          full;
	logic                          found;
	logic                          is_peek, is_acc, is_wr, is_del, is_clr;
	logic                          do_ins;
	lkvt_cmd_t                     cmd;
	logic [VALUE_BITS-1:0]         ins_val;
	logic signed [VALUE_BITS-1:0]  rv;
	logic [STATUS_W-1:0]           st;
	logic [CNT_W-1:0]              count_nxt;

	logic [CAPACITY-1:0]           hit;
	logic [CAPACITY:0]             seen;
	logic [VALUE_BITS-1:0]         rd   [CAPACITY+1];
	logic [KEY_BITS-1:0]           ckey [CAPACITY];
	logic [VALUE_BITS-1:0]         cval [CAPACITY];

	assign req_stall = rsp_valid && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign k = KEY_BITS'(key);
	assign v = VALUE_BITS'(value);

	assign is_peek = (action == ACT_PEEK) || (action > ACT_CLEAR);
	assign is_acc  = (action == ACT_ACCESS);
	assign is_wr   = (action == ACT_WRITE);
	assign is_del  = (action == ACT_DELETE);
	assign is_clr  = (action == ACT_CLEAR);

	assign full   = (count_q >= CNT_W'(CAPACITY));
	assign found  = seen[CAPACITY];
	assign do_ins = accept && (is_acc || is_wr) && !found && !full;

	assign cmd.del = accept && is_del && found;
	assign cmd.wr  = accept && is_wr && found;
	assign cmd.ins = do_ins;
	assign ins_val = is_wr ? v : '0;

	assign seen[0] = 1'b0;
	assign rd[0]   = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0]   nk;
		logic [VALUE_BITS-1:0] nv;

		if (i == CAPACITY - 1) begin : g_last
			assign nk = ckey[i];
			assign nv = cval[i];
		end else begin : g_mid
			assign nk = ckey[i+1];
			assign nv = cval[i+1];
		end

		lkvt_cell #(
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.req_key (k),
			.req_val (ins_val),
			.occupied(count_q > CNT_W'(i)),
			.tail    (count_q == CNT_W'(i)),
			.nxt_key (nk),
			.nxt_val (nv),
			.seen_in (seen[i]),
			.rd_in   (rd[i]),
			.hit     (hit[i]),
			.seen_out(seen[i+1]),
			.rd_out  (rd[i+1]),
			.key_q   (ckey[i]),
			.val_q   (cval[i])
		);
	end

	always_comb begin
		rv        = '0;
		st        = ST_OK;
		count_nxt = count_q;
		if (is_peek) begin
			rv = found ? rd[CAPACITY] : '0;
		end else if (is_acc || is_wr) begin
			if (found) begin
				rv = is_wr ? v : rd[CAPACITY];
			end else if (full) begin
				st = ST_FULL;
			end else begin
				rv        = ins_val;
				count_nxt = count_q + CNT_W'(1);
			end
		end else if (is_del) begin
			if (found) begin
				count_nxt = count_q - CNT_W'(1);
			end else begin
				st = ST_MISSING;
			end
		end else if (is_clr) begin
			count_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (accept) begin
				count_q   <= count_nxt;
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value  <= 32'(rv);
			was_found   <= found;
			status      <= st;
			entry_total <= TOTAL_W'(count_nxt);
		end
	end

	// keys in occupied cells are unique
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit))
		else $error("more than one cell matched the key");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL) |-> count_q == CNT_W'(CAPACITY))
		else $error("full reported while table has room");

	a_del_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("delete did not shrink the table");

endmodule

`default_nettype wire

// ----- rtl/lkvt_cell.sv -----
`default_nettype none

module lkvt_cell
	import lkvt_pkg::*;
#(
	parameter int KEY_BITS   = DEF_KEY_BITS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire lkvt_cmd_t             cmd,
	input  wire logic [KEY_BITS-1:0]   req_key,
	input  wire logic [VALUE_BITS-1:0] req_val,
	input  wire logic                  occupied,
	input  wire logic                  tail,
	input  wire logic [KEY_BITS-1:0]   nxt_key,
	input  wire logic [VALUE_BITS-1:0] nxt_val,
	input  wire logic                  seen_in,
	input  wire logic [VALUE_BITS-1:0] rd_in,
	output logic                       hit,
	output logic                       seen_out,
	output logic [VALUE_BITS-1:0]      rd_out,
	output logic [KEY_BITS-1:0]        key_q,
	output logic [VALUE_BITS-1:0]      val_q
);

	assign hit      = occupied && (key_q == req_key);
	assign seen_out = seen_in | hit;
	assign rd_out   = rd_in | (hit ? val_q : '0);

	// payload only; occupancy comes from the fill count
	always_ff @(posedge clk) begin
		if (cmd.del && seen_out) begin
			key_q <= nxt_key;
			val_q <= nxt_val;
		end else if (cmd.wr && hit) begin
			val_q <= req_val;
		end else if (cmd.ins && tail) begin
			key_q <= req_key;
			val_q <= req_val;
		end
	end

endmodule

`default_nettype wire

// ----- tb/lkvt_checker.sv -----
`default_nettype none

module lkvt_checker
	import lkvt_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int KEY_BITS   = DEF_KEY_BITS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	input  wire logic                 req_stall,
	input  wire logic [ACTION_W-1:0]  action,
	input  wire logic signed [31:0]   key,
	input  wire logic signed [31:0]   value,
	input  wire logic                 rsp_valid,
	input  wire logic                 rsp_stall,
	input  wire logic signed [31:0]   read_value,
	input  wire logic                 was_found,
	input  wire logic [STATUS_W-1:0]  status,
	input  wire logic [TOTAL_W-1:0]   entry_total,
	output int                        fail_count,
	output int                        outstanding
);

	// ports are 32 bits wide; wider stored fields behave like 32 here
	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam logic [31:0] KEY_MASK = 32'hFFFF_FFFF >> (32 - KW);
	localparam logic [31:0] VAL_MASK = 32'hFFFF_FFFF >> (32 - VW);

	typedef struct packed {
		logic signed [31:0]    read_value;
		logic                  was_found;
		logic [STATUS_W-1:0]   status;
		logic [TOTAL_W-1:0]    entry_total;
	} table_result_t;

	logic [31:0] tab_keys [CAPACITY];
	logic [31:0] tab_vals [CAPACITY];
	int tab_count = 0;
	int errors = 0;
	table_result_t result_q [$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	// applies one request word to the shadow table and returns the result word
	function automatic table_result_t apply_request(input logic [ACTION_W-1:0] act,
			input logic [31:0] k_in, input logic [31:0] v_in);
		table_result_t r;
		logic [31:0] k, v, rv;
		logic signed [31:0] rv_ext;
		int slot;
		k = k_in & KEY_MASK;
		v = v_in & VAL_MASK;
		rv = '0;
		slot = -1;
		r = '0;
		for (int i = 0; i < tab_count; i++)
			if (slot < 0 && tab_keys[i] == k)
				slot = i;
		r.was_found = (slot >= 0);
		r.status = ST_OK;
		case (act)
			ACT_ACCESS, ACT_WRITE: begin
				if (slot < 0) begin
					if (tab_count >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						tab_keys[tab_count] = k;
						tab_vals[tab_count] = (act == ACT_WRITE) ? v : '0;
						rv = tab_vals[tab_count];
						tab_count++;
					end
				end else begin
					if (act == ACT_WRITE)
						tab_vals[slot] = v;
					rv = tab_vals[slot];
				end
			end
			ACT_DELETE: begin
				if (slot < 0) begin
					r.status = ST_MISSING;
				end else begin
					for (int i = slot; i + 1 < tab_count; i++) begin
						tab_keys[i] = tab_keys[i + 1];
						tab_vals[i] = tab_vals[i + 1];
					end
					tab_count--;
				end
			end
			ACT_CLEAR: begin
				tab_count = 0;
			end
			default: begin
				// peek and the unused codes
				if (slot >= 0)
					rv = tab_vals[slot];
			end
		endcase
		rv_ext = rv << (32 - VW);
		rv_ext = rv_ext >>> (32 - VW);
		r.read_value = rv_ext;
		r.entry_total = TOTAL_W'(tab_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		table_result_t want;
		if (!arst_n) begin
			tab_count = 0;
			result_q.delete();
		end else begin
			if (req_valid && !req_stall)
				result_q.push_back(apply_request(action, key, value));
			if (rsp_valid && !rsp_stall) begin
				if (result_q.size() == 0) begin
					$error("result word with no request pending");
					errors++;
				end else begin
					want = result_q.pop_front();
					if (read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value,
							read_value);
						errors++;
					end
					if (was_found !== want.was_found) begin
						$error("was_found: expected %0d, got %0d", want.was_found,
							was_found);
						errors++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (entry_total !== want.entry_total) begin
						$error("entry_total: expected %0d, got %0d", want.entry_total,
							entry_total);
						errors++;
					end
				end
			end
		end
		fail_count  <= errors;
		outstanding <= result_q.size();
	end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
	import lkvt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int POOL_SIZE    = 20;

	localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] KEY_MIN = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;

	// codes above clear behave as peek
	localparam logic [ACTION_W-1:0] ACT_SPARE_LO = ACT_CLEAR + 1'b1;
	localparam logic [ACTION_W-1:0] ACT_SPARE_HI = '1;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  req_valid   = 1'b0;
	logic                  req_stall;
	logic [ACTION_W-1:0]   action      = ACT_PEEK;
	logic signed [31:0]    key         = '0;
	logic signed [31:0]    value       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall   = 1'b0;
	logic signed [31:0]    read_value;
	logic                  was_found;
	logic [STATUS_W-1:0]   status;
	logic [TOTAL_W-1:0]    entry_total;

	int fail_count;
	int outstanding;
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;
	logic [31:0] key_pool [POOL_SIZE];

	always #4 clk = ~clk;

	linear_key_value_table u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.key         (key),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.read_value  (read_value),
		.was_found   (was_found),
		.status      (status),
		.entry_total (entry_total)
	);

	lkvt_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.key         (key),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.read_value  (read_value),
		.was_found   (was_found),
		.status      (status),
		.entry_total (entry_total),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// result side: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic offer_request(input logic [ACTION_W-1:0] act, input logic [31:0] k,
			input logic [31:0] v);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		action    <= act;
		key       <= k;
		value     <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// outstanding is registered and lags the checker, so drop valid and wait before looking
	task automatic wait_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int count, input int pause_at, input int hold_at);
		logic [ACTION_W-1:0] act;
		logic [31:0] k, v;
		int pick;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = KEY_MAX;
		key_pool[1] = KEY_MIN;
		key_pool[2] = '0;
		key_pool[3] = '1;
		for (int n = 0; n < count; n++) begin
			if (n == pause_at)
				wait_drain();
			if (n == hold_at)
				hold_req <= hold_req + 1;
			pick = $urandom_range(99);
			if (pick < 20)
				act = ACT_PEEK;
			else if (pick < 42)
				act = ACT_ACCESS;
			else if (pick < 68)
				act = ACT_WRITE;
			else if (pick < 93)
				act = ACT_DELETE;
			else if (pick < 96)
				act = ACT_CLEAR;
			else
				act = ACTION_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
			// a small key pool keeps hits, deletes of present keys and a full table common
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				k = $urandom;
			case ($urandom_range(19))
				0:       v = VAL_MIN;
				1:       v = VAL_MAX;
				2:       v = '0;
				3:       v = '1;
				default: v = $urandom;
			endcase
			offer_request(act, k, v);
		end
	endtask

	initial begin
		#(LIMIT_CYCLES * 8);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: peek miss, delete miss
		offer_request(ACT_PEEK, '0, '0);
		offer_request(ACT_DELETE, KEY_MIN, '0);
		offer_request(ACT_WRITE, KEY_MAX, VAL_MIN);
		offer_request(ACT_WRITE, KEY_MIN, VAL_MAX);
		offer_request(ACT_ACCESS, '0, VAL_MAX);
		offer_request(ACT_ACCESS, KEY_MAX, '0);
		offer_request(ACT_SPARE_HI, KEY_MIN, '0);
		offer_request(ACT_WRITE, '1, '1);
		for (int i = 0; i < 12; i++)
			offer_request(ACT_WRITE, 32'(i + 100), $urandom);
		// table full now
		offer_request(ACT_ACCESS, 32'd555, '0);
		offer_request(ACT_WRITE, 32'd556, VAL_MAX);
		offer_request(ACT_DELETE, KEY_MAX, '0);
		offer_request(ACT_DELETE, 32'd111, '0);
		offer_request(ACT_PEEK, KEY_MIN, '0);
		offer_request(ACT_CLEAR, KEY_MIN, '0);
		offer_request(ACT_PEEK, KEY_MIN, '0);
		wait_drain();

		idle_pct  = 29;
		stall_pct = 61;
		run_random(617, 300, -1);
		wait_drain();

		idle_pct  = 61;
		stall_pct = 29;
		run_random(617, -1, -1);
		wait_drain();

		idle_pct  = 0;
		stall_pct = 0;
		run_random(616, -1, 200);
		wait_drain();
		repeat (10) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
